@@ rtl/core/mrpast_pkg.sv @@
package mrpast_pkg;

    localparam int IDX_W    = 6;
    localparam int MODE_W   = 5;
    localparam int TIME_W   = 63;
    localparam int PERIOD_W = 40;
    localparam int DL_W     = 64;
    localparam int APP_W    = 4;
    localparam int RG_W     = 2;
    localparam int NT_W     = 2;
    localparam int SD_W     = 3;

    localparam int NUM_ATTRIBUTES_DEFAULT = 64;
    localparam logic [PERIOD_W-1:0] LEAVE_PERIOD_RESET = 40'd1000000000;

    // Events carried in the mode field.
    localparam logic [MODE_W-1:0] EV_BEGIN     = 5'd0;
    localparam logic [MODE_W-1:0] EV_NEW       = 5'd1;
    localparam logic [MODE_W-1:0] EV_JOIN      = 5'd2;
    localparam logic [MODE_W-1:0] EV_LV        = 5'd3;
    localparam logic [MODE_W-1:0] EV_RX_NEW    = 5'd4;
    localparam logic [MODE_W-1:0] EV_RX_JOININ = 5'd5;
    localparam logic [MODE_W-1:0] EV_RX_IN     = 5'd6;
    localparam logic [MODE_W-1:0] EV_RX_JOINMT = 5'd7;
    localparam logic [MODE_W-1:0] EV_RX_MT     = 5'd8;
    localparam logic [MODE_W-1:0] EV_RX_LV     = 5'd9;
    localparam logic [MODE_W-1:0] EV_RX_LVA    = 5'd10;
    localparam logic [MODE_W-1:0] EV_TX        = 5'd11;
    localparam logic [MODE_W-1:0] EV_TX_LVA    = 5'd12;
    localparam logic [MODE_W-1:0] EV_REDECLARE = 5'd13;
    localparam logic [MODE_W-1:0] EV_PERIODIC  = 5'd14;
    localparam logic [MODE_W-1:0] EV_FLUSH     = 5'd15;
    localparam logic [MODE_W-1:0] EV_TIMER     = 5'd16;

    // Applicant states.
    localparam logic [APP_W-1:0] AP_VO = 4'd0;
    localparam logic [APP_W-1:0] AP_VP = 4'd1;
    localparam logic [APP_W-1:0] AP_VN = 4'd2;
    localparam logic [APP_W-1:0] AP_AN = 4'd3;
    localparam logic [APP_W-1:0] AP_AA = 4'd4;
    localparam logic [APP_W-1:0] AP_QA = 4'd5;
    localparam logic [APP_W-1:0] AP_LA = 4'd6;
    localparam logic [APP_W-1:0] AP_AO = 4'd7;
    localparam logic [APP_W-1:0] AP_QO = 4'd8;
    localparam logic [APP_W-1:0] AP_AP = 4'd9;
    localparam logic [APP_W-1:0] AP_QP = 4'd10;
    localparam logic [APP_W-1:0] AP_LO = 4'd11;

    // Registrar states.
    localparam logic [RG_W-1:0] RG_MT = 2'd0;
    localparam logic [RG_W-1:0] RG_IN = 2'd1;
    localparam logic [RG_W-1:0] RG_LV = 2'd2;

    // Notify codes.
    localparam logic [NT_W-1:0] NT_NONE  = 2'd0;
    localparam logic [NT_W-1:0] NT_NEW   = 2'd1;
    localparam logic [NT_W-1:0] NT_JOIN  = 2'd2;
    localparam logic [NT_W-1:0] NT_LEAVE = 2'd3;

    // Send codes.
    localparam logic [SD_W-1:0] SD_NONE   = 3'd0;
    localparam logic [SD_W-1:0] SD_NEW    = 3'd1;
    localparam logic [SD_W-1:0] SD_JOININ = 3'd2;
    localparam logic [SD_W-1:0] SD_IN     = 3'd3;
    localparam logic [SD_W-1:0] SD_JOINMT = 3'd4;
    localparam logic [SD_W-1:0] SD_MT     = 3'd5;
    localparam logic [SD_W-1:0] SD_LV     = 3'd6;

    // One attribute entry as held in the table memory.
    typedef struct packed {
        logic [APP_W-1:0] app;
        logic [RG_W-1:0]  rg;
        logic [DL_W-1:0]  deadline;
        logic             joined;
        logic [SD_W-1:0]  pend;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        app:      AP_VO,
        rg:       RG_MT,
        deadline: '0,
        joined:   1'b0,
        pend:     SD_NONE
    };

    // Result fields produced by the transition logic.
    typedef struct packed {
        logic [APP_W-1:0] app;
        logic [RG_W-1:0]  rg;
        logic [NT_W-1:0]  notify;
        logic [SD_W-1:0]  send;
        logic             stored;
        logic             timer_running;
    } result_t;

endpackage

@@ rtl/core/mrpast_mem.sv @@
module mrpast_mem
    import mrpast_pkg::*;
#(
    parameter int DEPTH  = NUM_ATTRIBUTES_DEFAULT,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/mrpast_rules.sv @@
module mrpast_rules
    import mrpast_pkg::*;
(
    input  entry_t              cur,
    input  logic [MODE_W-1:0]   mode,
    input  logic [TIME_W-1:0]   now,
    input  logic [PERIOD_W-1:0] period,
    output entry_t              nxt,
    output result_t             res
);

    logic [DL_W-1:0]  deadline_sum;
    logic             deadline_passed;

    assign deadline_sum    = {1'b0, now} + {{(DL_W-PERIOD_W){1'b0}}, period};
    assign deadline_passed = {1'b0, now} > cur.deadline;

    always_comb
    begin
        logic             run;
        logic             rin;
        logic [DL_W-1:0]  dl;
        logic             jn;
        logic [RG_W-1:0]  rg;
        logic [APP_W-1:0] s;
        logic [NT_W-1:0]  nt;
        logic [SD_W-1:0]  sd;
        logic [SD_W-1:0]  pend;
        logic             stored;

        run    = 1'b1;
        rin    = 1'b0;
        dl     = cur.deadline;
        jn     = cur.joined;
        rg     = cur.rg;
        s      = cur.app;
        nt     = NT_NONE;
        sd     = SD_NONE;
        pend   = cur.pend;
        stored = 1'b0;

        if (mode > EV_TIMER)
        begin
            run = 1'b0;
        end
        else if (mode == EV_TIMER)
        begin
            if (dl != '0 && deadline_passed)
            begin
                dl = '0;
            end
            else
            begin
                run = 1'b0;
            end
        end
        else if (mode == EV_BEGIN)
        begin
            dl = '0;
        end
        else if (mode == EV_NEW || mode == EV_JOIN)
        begin
            jn = 1'b1;
        end

        if (run)
        begin
            // Registrar first; the applicant sees the updated registrar state.
            case (mode)
                EV_BEGIN:
                begin
                    rg = RG_MT;
                end
                EV_RX_NEW:
                begin
                    nt = NT_NEW;
                    if (rg == RG_LV)
                    begin
                        dl = '0;
                    end
                    rg = RG_IN;
                end
                EV_RX_JOININ, EV_RX_JOINMT:
                begin
                    if (rg == RG_LV)
                    begin
                        dl = '0;
                    end
                    else if (rg == RG_MT)
                    begin
                        nt = NT_JOIN;
                    end
                    rg = RG_IN;
                end
                EV_RX_LV, EV_RX_LVA, EV_TX_LVA, EV_REDECLARE:
                begin
                    if (rg == RG_IN)
                    begin
                        dl = deadline_sum;
                        rg = RG_LV;
                    end
                end
                EV_FLUSH:
                begin
                    if (rg == RG_LV)
                    begin
                        nt = NT_LEAVE;
                    end
                    rg = RG_MT;
                end
                EV_TIMER:
                begin
                    if (rg == RG_LV)
                    begin
                        nt = NT_LEAVE;
                        rg = RG_MT;
                    end
                end
                default:
                begin
                end
            endcase

            rin = (rg == RG_IN);

            case (mode)
                EV_BEGIN:
                begin
                    s = AP_VO;
                end
                EV_NEW:
                begin
                    if (s != AP_VN && s != AP_AN)
                    begin
                        s = AP_VN;
                    end
                end
                EV_JOIN:
                begin
                    if (s == AP_VO || s == AP_LO)      s = AP_VP;
                    else if (s == AP_LA)               s = AP_AA;
                    else if (s == AP_AO)               s = AP_AP;
                    else if (s == AP_QO)               s = AP_QP;
                end
                EV_LV:
                begin
                    if (s == AP_VP)                    s = AP_VO;
                    else if (s == AP_VN || s == AP_AN || s == AP_AA || s == AP_QA)
                                                       s = AP_LA;
                    else if (s == AP_AP)               s = AP_AO;
                    else if (s == AP_QP)               s = AP_QO;
                end
                EV_RX_JOININ, EV_RX_IN:
                begin
                    if (mode == EV_RX_JOININ)
                    begin
                        if (s == AP_VO)                s = AP_AO;
                        else if (s == AP_VP)           s = AP_AP;
                        else if (s == AP_AA)           s = AP_QA;
                        else if (s == AP_AO)           s = AP_QO;
                        else if (s == AP_AP)           s = AP_QP;
                    end
                    if (s == AP_AA)                    s = AP_QA;
                end
                EV_RX_JOINMT, EV_RX_MT:
                begin
                    if (s == AP_QA)                    s = AP_AA;
                    else if (s == AP_QO)               s = AP_AO;
                    else if (s == AP_QP)               s = AP_AP;
                    else if (s == AP_LO)               s = AP_VO;
                end
                EV_RX_LV, EV_RX_LVA, EV_REDECLARE:
                begin
                    if (s == AP_VO || s == AP_AO || s == AP_QO)
                                                       s = AP_LO;
                    else if (s == AP_AN)               s = AP_VN;
                    else if (s == AP_AA || s == AP_QA || s == AP_AP || s == AP_QP)
                                                       s = AP_VP;
                end
                EV_PERIODIC:
                begin
                    if (s == AP_QA)                    s = AP_AA;
                    else if (s == AP_QP)               s = AP_AP;
                end
                EV_TX:
                begin
                    if (s == AP_VP || s == AP_AA || s == AP_AP)
                                                       sd = rin ? SD_JOININ : SD_JOINMT;
                    else if (s == AP_VN || s == AP_AN) sd = SD_NEW;
                    else if (s == AP_LA)               sd = SD_LV;
                    else if (s == AP_LO)               sd = rin ? SD_IN : SD_MT;

                    if (s == AP_VP)                    s = AP_AA;
                    else if (s == AP_VN)               s = AP_AN;
                    else if (s == AP_AN)               s = rin ? AP_QA : AP_AA;
                    else if (s == AP_AA || s == AP_AP) s = AP_QA;
                    else if (s == AP_LA || s == AP_LO) s = AP_VO;
                end
                EV_TX_LVA:
                begin
                    if (s == AP_VP)                    sd = rin ? SD_IN : SD_MT;
                    else if (s == AP_VN || s == AP_AN) sd = SD_NEW;
                    else if (s == AP_AA || s == AP_QA || s == AP_AP || s == AP_QP)
                                                       sd = rin ? SD_JOININ : SD_JOINMT;

                    if (s == AP_VO || s == AP_LA || s == AP_AO || s == AP_QO)
                                                       s = AP_LO;
                    else if (s == AP_VP)               s = AP_AA;
                    else if (s == AP_VN)               s = AP_AN;
                    else if (s == AP_AN || s == AP_AA || s == AP_AP || s == AP_QP)
                                                       s = AP_QA;
                end
                default:
                begin
                end
            endcase

            if (jn)
            begin
                pend   = sd;
                stored = 1'b1;
            end
            if (mode == EV_LV)
            begin
                jn = 1'b0;
            end
        end

        nxt.app      = s;
        nxt.rg       = rg;
        nxt.deadline = dl;
        nxt.joined   = jn;
        nxt.pend     = pend;

        res.app           = s;
        res.rg            = rg;
        res.notify        = nt;
        res.send          = sd;
        res.stored        = stored;
        res.timer_running = (dl != '0);
    end

endmodule

@@ rtl/core/mrp_attribute_state_table.sv @@
// MRP attribute state table: applicant and registrar state per attribute.
// Input channel (in_valid/in_ready): one event per item, naming the
// attribute, the event code in mode and the current time in nanoseconds.
// Output channel (out_valid/out_ready): one result item per event, with the
// new applicant and registrar states, notify and send codes, whether the
// send was kept as pending, and whether the leave timer is armed.
// Configuration channel (cfg_valid/cfg_ready): writes the leave period;
// always ready. The user writes it only while no event is in flight; the
// block itself does not enforce this. The table read is registered; the
// result then enters the output register once that register is free.
// One event is in the block at a time: the synchronous table read, then
// the update and write-back to the same entry, before the next is taken.
// After reset the table is swept to its reset values, one entry per cycle,
// until all NUM_ATTRIBUTES entries are written; in_ready stays low then.
// When the receiver stalls, the result holds in the output register, the
// next event may be accepted and read, and its write-back waits until the
// output register is free.
module mrp_attribute_state_table
    import mrpast_pkg::*;
#(
    parameter int NUM_ATTRIBUTES = NUM_ATTRIBUTES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] leave_period_ns,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IDX_W-1:0]    attribute_index,
    input  logic [MODE_W-1:0]   mode,
    input  logic [TIME_W-1:0]   time_now_ns,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    entry_index,
    output logic [APP_W-1:0]    applicant_state_out,
    output logic [RG_W-1:0]     registrar_state_out,
    output logic [NT_W-1:0]     notify_code,
    output logic [SD_W-1:0]     send_code,
    output logic                send_stored,
    output logic                leave_timer_running
);

    localparam int ADDR_W = (NUM_ATTRIBUTES > 1) ? $clog2(NUM_ATTRIBUTES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ATTRIBUTES - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_BUSY  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [PERIOD_W-1:0] period_reg, period_next;

    logic [IDX_W-1:0]    idx_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                in_range_reg;

    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg;
    logic [IDX_W-1:0]    out_idx_reg;

    logic                in_accept;
    logic                out_free;
    logic                commit;
    logic                in_range;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    entry_t              mem_wr_data;
    entry_t              mem_rd_data;

    entry_t              entry_nxt;
    result_t             rule_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign commit    = (state_reg == S_BUSY) && out_free;
    assign in_range  = 32'(attribute_index) < 32'(NUM_ATTRIBUTES);

    mrpast_mem #(
        .DEPTH  (NUM_ATTRIBUTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (ADDR_W'(attribute_index)),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    mrpast_rules u_rules (
        .cur    (mem_rd_data),
        .mode   (mode_reg),
        .now    (now_reg),
        .period (period_reg),
        .nxt    (entry_nxt),
        .res    (rule_res)
    );

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = ADDR_W'(idx_reg);
        mem_wr_data = entry_nxt;
        if (state_reg == S_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_reg;
            mem_wr_data = ENTRY_RESET;
        end
        else if (commit && in_range_reg)
        begin
            mem_wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign period_next    = (cfg_valid && cfg_ready) ? leave_period_ns : period_reg;
    assign out_valid_next = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            period_reg    <= LEAVE_PERIOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            period_reg    <= period_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            idx_reg      <= attribute_index;
            mode_reg     <= mode;
            now_reg      <= time_now_ns;
            in_range_reg <= in_range;
        end
        if (commit)
        begin
            out_idx_reg <= idx_reg;
            // An index beyond the table reports zeros in every other field.
            out_res_reg <= in_range_reg ? rule_res : '0;
        end
    end

    assign out_valid           = out_valid_reg;
    assign entry_index         = out_idx_reg;
    assign applicant_state_out = out_res_reg.app;
    assign registrar_state_out = out_res_reg.rg;
    assign notify_code         = out_res_reg.notify;
    assign send_code           = out_res_reg.send;
    assign send_stored         = out_res_reg.stored;
    assign leave_timer_running = out_res_reg.timer_running;

endmodule

@@ rtl/core/mrpast_checker.sv @@
module mrpast_checker
    import mrpast_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [IDX_W-1:0]    entry_index,
    input  logic [APP_W-1:0]    applicant_state_out,
    input  logic [RG_W-1:0]     registrar_state_out,
    input  logic [NT_W-1:0]     notify_code,
    input  logic [SD_W-1:0]     send_code,
    input  logic                send_stored,
    input  logic                leave_timer_running
);

    // A stalled result item keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_index)
            && $stable(applicant_state_out) && $stable(registrar_state_out)
            && $stable(notify_code) && $stable(send_code)
            && $stable(send_stored) && $stable(leave_timer_running))
        else $error("result item changed while stalled");

    // Only one event is in the block at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an event is in flight");

    // New and join notifications leave the registrar in IN.
    a_notify_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (notify_code == NT_NEW || notify_code == NT_JOIN)
            |-> registrar_state_out == RG_IN)
        else $error("new or join notify without registrar IN");

    // A leave notification leaves the registrar in MT.
    a_notify_leave: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && notify_code == NT_LEAVE |-> registrar_state_out == RG_MT)
        else $error("leave notify without registrar MT");

    // Reported states and send codes stay within their defined ranges.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> applicant_state_out <= AP_LO && registrar_state_out <= RG_LV
            && send_code <= SD_LV)
        else $error("result code out of range");

endmodule

bind mrp_attribute_state_table mrpast_checker u_mrpast_checker (.*);

@@ tb/tb_mrp_attribute_state_table.sv @@
module tb_mrp_attribute_state_table;
    import mrpast_pkg::*;

    localparam int NUM_ENTRIES = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 335;
    localparam int NUM_PHASES  = 5;
    localparam int LONG_HOLD   = 160;
    localparam int DIR_ROWS    = 29;

    // Highest event code; everything above EV_TIMER is undefined.
    localparam logic [MODE_W-1:0]   EV_UNDEF_TOP = 5'd31;
    localparam logic [TIME_W-1:0]   TIME_MAX     = '1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = '1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [APP_W-1:0] app;
        logic [RG_W-1:0]  rg;
        logic [NT_W-1:0]  notify;
        logic [SD_W-1:0]  send;
        logic             stored;
        logic             timer_on;
    } attr_result_t;

    typedef enum logic {ROW_EVENT, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e           kind;
        logic [PERIOD_W-1:0] period;
        logic [IDX_W-1:0]    idx;
        logic [MODE_W-1:0]   md;
        logic [TIME_W-1:0]   t;
        logic                typed;
        attr_result_t        want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] leave_period_ns = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [IDX_W-1:0]    attribute_index = '0;
    logic [MODE_W-1:0]   mode = '0;
    logic [TIME_W-1:0]   time_now_ns = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [IDX_W-1:0]    entry_index;
    logic [APP_W-1:0]    applicant_state_out;
    logic [RG_W-1:0]     registrar_state_out;
    logic [NT_W-1:0]     notify_code;
    logic [SD_W-1:0]     send_code;
    logic                send_stored;
    logic                leave_timer_running;

    always #5 clk = ~clk;

    mrp_attribute_state_table #(
        .NUM_ATTRIBUTES(NUM_ENTRIES)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .leave_period_ns     (leave_period_ns),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .attribute_index     (attribute_index),
        .mode                (mode),
        .time_now_ns         (time_now_ns),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .entry_index         (entry_index),
        .applicant_state_out (applicant_state_out),
        .registrar_state_out (registrar_state_out),
        .notify_code         (notify_code),
        .send_code           (send_code),
        .send_stored         (send_stored),
        .leave_timer_running (leave_timer_running)
    );

    // Shadow copy of the attribute table and the leave period.
    logic [APP_W-1:0]    app_tab    [NUM_ENTRIES] = '{default: AP_VO};
    logic [RG_W-1:0]     rg_tab     [NUM_ENTRIES] = '{default: RG_MT};
    logic [DL_W-1:0]     dl_tab     [NUM_ENTRIES] = '{default: '0};
    logic                joined_tab [NUM_ENTRIES] = '{default: 1'b0};
    logic [PERIOD_W-1:0] period_now = LEAVE_PERIOD_RESET;

    attr_result_t expected_q [$];
    int           error_count = 0;
    int           results_seen = 0;
    int           send_burst = 0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_EVENT, '0, 6'd0, EV_PERIODIC, 63'd0, 1'b1,
          '{6'd0, AP_VO, RG_MT, NT_NONE, SD_NONE, 1'b0, 1'b0}},
        '{ROW_EVENT, '0, 6'd63, EV_TIMER, TIME_MAX, 1'b1,
          '{6'd63, AP_VO, RG_MT, NT_NONE, SD_NONE, 1'b0, 1'b0}},
        '{ROW_EVENT, '0, 6'd63, EV_UNDEF_TOP, 63'd0, 1'b1,
          '{6'd63, AP_VO, RG_MT, NT_NONE, SD_NONE, 1'b0, 1'b0}},
        '{ROW_EVENT, '0, 6'd5, EV_NEW, 63'd100, 1'b1,
          '{6'd5, AP_VN, RG_MT, NT_NONE, SD_NONE, 1'b1, 1'b0}},
        '{ROW_EVENT, '0, 6'd5, EV_TX, 63'd200, 1'b1,
          '{6'd5, AP_AN, RG_MT, NT_NONE, SD_NEW, 1'b1, 1'b0}},
        '{ROW_EVENT, '0, 6'd5, EV_RX_NEW, 63'd300, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd5, EV_TX, 63'd400, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd5, EV_RX_LV, 63'd1000, 1'b0, '0},
        // The deadline itself does not fire the timer; one past it does.
        '{ROW_EVENT, '0, 6'd5, EV_TIMER, 63'd1000001000, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd5, EV_TIMER, 63'd1000001001, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd9, EV_RX_JOININ, 63'd2000, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd9, EV_REDECLARE, 63'd2100, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd9, EV_RX_JOINMT, 63'd2200, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd9, EV_TX_LVA, 63'd2300, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd9, EV_FLUSH, 63'd2400, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd9, EV_BEGIN, 63'd2500, 1'b1,
          '{6'd9, AP_VO, RG_MT, NT_NONE, SD_NONE, 1'b0, 1'b0}},
        '{ROW_EVENT, '0, 6'd20, EV_JOIN, 63'd3000, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd20, EV_RX_IN, 63'd3100, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd20, EV_RX_MT, 63'd3200, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd20, EV_LV, 63'd3300, 1'b0, '0},
        // With a zero period at time zero the deadline sum is zero: not armed.
        '{ROW_CFG, 40'd0, '0, EV_BEGIN, '0, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd1, EV_RX_NEW, 63'd0, 1'b1,
          '{6'd1, AP_VO, RG_IN, NT_NEW, SD_NONE, 1'b0, 1'b0}},
        '{ROW_EVENT, '0, 6'd1, EV_RX_LV, 63'd0, 1'b1,
          '{6'd1, AP_LO, RG_LV, NT_NONE, SD_NONE, 1'b0, 1'b0}},
        '{ROW_EVENT, '0, 6'd1, EV_TIMER, 63'd5, 1'b1,
          '{6'd1, AP_LO, RG_LV, NT_NONE, SD_NONE, 1'b0, 1'b0}},
        '{ROW_CFG, PERIOD_MAX, '0, EV_BEGIN, '0, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd42, EV_RX_JOININ, TIME_MAX, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd42, EV_RX_LVA, TIME_MAX, 1'b0, '0},
        '{ROW_EVENT, '0, 6'd42, EV_TIMER, TIME_MAX, 1'b0, '0},
        '{ROW_CFG, 40'd1, '0, EV_BEGIN, '0, 1'b0, '0}
    };

    // Registrar rules first, then applicant rules against the new registrar.
    function automatic attr_result_t mrp_transition(input logic [IDX_W-1:0] idx,
                                                    input logic [MODE_W-1:0] md,
                                                    input logic [TIME_W-1:0] now);
        attr_result_t     r;
        logic             run;
        logic             rin;
        logic [APP_W-1:0] s;
        logic [RG_W-1:0]  g;
        logic [NT_W-1:0]  nt;
        logic [SD_W-1:0]  sd;
        r   = '0;
        run = 1'b1;
        nt  = NT_NONE;
        sd  = SD_NONE;
        if (md > EV_TIMER) begin
            run = 1'b0;
        end else if (md == EV_TIMER) begin
            if (dl_tab[idx] != '0 && {1'b0, now} > dl_tab[idx])
                dl_tab[idx] = '0;
            else
                run = 1'b0;
        end else if (md == EV_BEGIN) begin
            dl_tab[idx] = '0;
        end else if (md == EV_NEW || md == EV_JOIN) begin
            joined_tab[idx] = 1'b1;
        end

        if (run) begin
            g = rg_tab[idx];
            case (md)
                EV_BEGIN: g = RG_MT;
                EV_RX_NEW:
                begin
                    nt = NT_NEW;
                    if (g == RG_LV) dl_tab[idx] = '0;
                    g = RG_IN;
                end
                EV_RX_JOININ, EV_RX_JOINMT:
                begin
                    if (g == RG_LV) dl_tab[idx] = '0;
                    else if (g == RG_MT) nt = NT_JOIN;
                    g = RG_IN;
                end
                EV_RX_LV, EV_RX_LVA, EV_TX_LVA, EV_REDECLARE:
                begin
                    if (g == RG_IN) begin
                        dl_tab[idx] = {1'b0, now} + {24'd0, period_now};
                        g = RG_LV;
                    end
                end
                EV_FLUSH:
                begin
                    if (g == RG_LV) nt = NT_LEAVE;
                    g = RG_MT;
                end
                EV_TIMER:
                begin
                    if (g == RG_LV) begin
                        nt = NT_LEAVE;
                        g = RG_MT;
                    end
                end
                default: ;
            endcase
            rg_tab[idx] = g;
            rin = (g == RG_IN);

            s = app_tab[idx];
            case (md)
                EV_BEGIN: s = AP_VO;
                EV_NEW: if (s != AP_VN && s != AP_AN) s = AP_VN;
                EV_JOIN:
                    case (s)
                        AP_VO, AP_LO: s = AP_VP;
                        AP_LA: s = AP_AA;
                        AP_AO: s = AP_AP;
                        AP_QO: s = AP_QP;
                        default: ;
                    endcase
                EV_LV:
                    case (s)
                        AP_VP: s = AP_VO;
                        AP_VN, AP_AN, AP_AA, AP_QA: s = AP_LA;
                        AP_AP: s = AP_AO;
                        AP_QP: s = AP_QO;
                        default: ;
                    endcase
                EV_RX_JOININ, EV_RX_IN:
                begin
                    if (md == EV_RX_JOININ) begin
                        case (s)
                            AP_VO: s = AP_AO;
                            AP_VP: s = AP_AP;
                            AP_AO: s = AP_QO;
                            AP_AP: s = AP_QP;
                            default: ;
                        endcase
                    end
                    if (s == AP_AA) s = AP_QA;
                end
                EV_RX_JOINMT, EV_RX_MT:
                    case (s)
                        AP_QA: s = AP_AA;
                        AP_QO: s = AP_AO;
                        AP_QP: s = AP_AP;
                        AP_LO: s = AP_VO;
                        default: ;
                    endcase
                EV_RX_LV, EV_RX_LVA, EV_REDECLARE:
                    case (s)
                        AP_VO, AP_AO, AP_QO: s = AP_LO;
                        AP_AN: s = AP_VN;
                        AP_AA, AP_QA, AP_AP, AP_QP: s = AP_VP;
                        default: ;
                    endcase
                EV_PERIODIC:
                    case (s)
                        AP_QA: s = AP_AA;
                        AP_QP: s = AP_AP;
                        default: ;
                    endcase
                EV_TX:
                begin
                    case (s)
                        AP_VP, AP_AA, AP_AP: sd = rin ? SD_JOININ : SD_JOINMT;
                        AP_VN, AP_AN: sd = SD_NEW;
                        AP_LA: sd = SD_LV;
                        AP_LO: sd = rin ? SD_IN : SD_MT;
                        default: ;
                    endcase
                    case (s)
                        AP_VP: s = AP_AA;
                        AP_VN: s = AP_AN;
                        AP_AN: s = rin ? AP_QA : AP_AA;
                        AP_AA, AP_AP: s = AP_QA;
                        AP_LA, AP_LO: s = AP_VO;
                        default: ;
                    endcase
                end
                EV_TX_LVA:
                begin
                    case (s)
                        AP_VP: sd = rin ? SD_IN : SD_MT;
                        AP_VN, AP_AN: sd = SD_NEW;
                        AP_AA, AP_QA, AP_AP, AP_QP: sd = rin ? SD_JOININ : SD_JOINMT;
                        default: ;
                    endcase
                    case (s)
                        AP_VO, AP_LA, AP_AO, AP_QO: s = AP_LO;
                        AP_VP: s = AP_AA;
                        AP_VN: s = AP_AN;
                        AP_AN, AP_AA, AP_AP, AP_QP: s = AP_QA;
                        default: ;
                    endcase
                end
                default: ;
            endcase
            app_tab[idx] = s;

            r.stored = joined_tab[idx];
            if (md == EV_LV) joined_tab[idx] = 1'b0;
        end

        r.idx      = idx;
        r.app      = app_tab[idx];
        r.rg       = rg_tab[idx];
        r.notify   = nt;
        r.send     = sd;
        r.timer_on = (dl_tab[idx] != '0);
        return r;
    endfunction

    task automatic send_event(input logic [IDX_W-1:0] idx, input logic [MODE_W-1:0] md,
                              input logic [TIME_W-1:0] t);
        int gap;
        if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 9) == 0) send_burst = $urandom_range(10, 40);
            gap = $urandom_range(0, 12);
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        attribute_index <= idx;
        mode            <= md;
        time_now_ns     <= t;
        do @(posedge clk); while (in_ready !== 1'b1);
        expected_q.push_back(mrp_transition(idx, md, t));
    endtask

    // Stop offering items and wait until every result is back and the
    // pipeline has settled.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_leave_period(input logic [PERIOD_W-1:0] val);
        drain_block();
        cfg_valid       <= 1'b1;
        leave_period_ns <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid  <= 1'b0;
        period_now = val;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result side: random stalls, plus long hold-offs that back the block up.
    initial begin
        int           stall;
        int           recv_burst;
        attr_result_t want;
        recv_burst = 0;
        forever begin
            if (results_seen == 400 || results_seen == 1000) begin
                stall = LONG_HOLD;
            end else if (recv_burst > 0) begin
                recv_burst--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 9) == 0) recv_burst = $urandom_range(10, 40);
                stall = $urandom_range(0, 12);
            end
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (expected_q.size() == 0) begin
                $error("result item for entry %0d with nothing expected", entry_index);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("entry_index", want.idx, entry_index);
                check_field("applicant_state_out", want.app, applicant_state_out);
                check_field("registrar_state_out", want.rg, registrar_state_out);
                check_field("notify_code", want.notify, notify_code);
                check_field("send_code", want.send, send_code);
                check_field("send_stored", want.stored, send_stored);
                check_field("leave_timer_running", want.timer_on, leave_timer_running);
            end
            results_seen++;
        end
    end

    initial begin
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
        $display("tb_mrp_attribute_state_table: done, errors");
        $finish;
    end

    initial begin
        int                  row;
        int                  ph;
        int                  n;
        int                  roll;
        logic [IDX_W-1:0]    idx;
        logic [IDX_W-1:0]    last_idx;
        logic [IDX_W-1:0]    hot_base;
        logic [MODE_W-1:0]   md;
        logic [TIME_W-1:0]   t;
        logic [TIME_W-1:0]   now_base;
        logic [63:0]         wide;
        logic [PERIOD_W-1:0] phase_period [NUM_PHASES];

        last_idx = '0;
        now_base = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++) begin
            if (dir_tab[row].kind == ROW_CFG) begin
                write_leave_period(dir_tab[row].period);
            end else begin
                send_event(dir_tab[row].idx, dir_tab[row].md, dir_tab[row].t);
                // Rows with a typed result replace the computed one.
                if (dir_tab[row].typed) begin
                    void'(expected_q.pop_back());
                    expected_q.push_back(dir_tab[row].want);
                end
            end
        end

        phase_period[0] = 40'd1;
        phase_period[1] = PERIOD_MAX;
        phase_period[2] = {8'($urandom), 32'($urandom)} | 40'd1;
        phase_period[3] = LEAVE_PERIOD_RESET;
        phase_period[4] = 40'($urandom_range(1, 5000));

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_leave_period(phase_period[ph]);
            hot_base = 6'($urandom_range(0, 63));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2) drain_block();

                // Most events hit a few attributes, often the same one twice
                // in a row, so state carries from event to event.
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    idx = last_idx;
                else if (roll < 85)
                    idx = hot_base + 6'($urandom_range(0, 3));
                else
                    idx = 6'($urandom_range(0, 63));

                roll = $urandom_range(0, 99);
                if (roll < 3)
                    md = 5'($urandom_range(17, 31));
                else if (roll < 5)
                    md = EV_BEGIN;
                else if (roll < 9)
                    md = EV_FLUSH;
                else if (roll < 22)
                    md = EV_TIMER;
                else
                    md = 5'($urandom_range(1, 14));

                now_base = now_base + 63'($urandom_range(0, 3000));
                roll = $urandom_range(0, 99);
                if (md == EV_TIMER && dl_tab[idx] != '0) begin
                    // Land just before, on, or past the armed deadline.
                    if (roll < 25)
                        wide = dl_tab[idx] - 64'd1;
                    else if (roll < 50)
                        wide = dl_tab[idx];
                    else if (roll < 75)
                        wide = dl_tab[idx] + 64'd1;
                    else
                        wide = dl_tab[idx] + 64'($urandom_range(0, 1000));
                    t = (wide > {1'b0, TIME_MAX}) ? TIME_MAX : wide[TIME_W-1:0];
                end else begin
                    wide = {$urandom, $urandom};
                    if (roll < 80)
                        t = now_base;
                    else if (roll < 85)
                        t = '0;
                    else if (roll < 90)
                        t = TIME_MAX;
                    else
                        t = wide[TIME_W-1:0];
                end

                send_event(idx, md, t);
                last_idx = idx;
            end
        end

        drain_block();
        if (error_count == 0)
            $display("tb_mrp_attribute_state_table: done, clean");
        else
            $display("tb_mrp_attribute_state_table: done, errors");
        $finish;
    end

endmodule
